>>> sv/pfa_pkg.sv
`timescale 1ns / 1ps

package pfa_pkg;

  // Request kinds
  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  // Result codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_EMPTY  = 2'd1;
  localparam logic [1:0] STAT_RANGE  = 2'd2;
  localparam logic [1:0] STAT_DOUBLE = 2'd3;

  localparam int IDX_W   = 20;
  localparam int OFRM_W  = 12;
  localparam int OCNT_W  = 12;
  localparam int IN_W    = 24;
  localparam int OUT_W   = 32;

  // Request item, first field in the high bits
  typedef struct packed {
    logic [IDX_W-1:0] frame_index;
    logic [1:0]       action;
  } req_t;

  // Result item, first field in the high bits
  typedef struct packed {
    logic [OCNT_W-1:0] free_count;
    logic [OFRM_W-1:0] alloc_frame;
    logic [1:0]        status;
  } res_t;

endpackage

>>> sv/page_frame_allocator.sv
`timescale 1ns / 1ps

// Page-frame allocator with a LIFO free stack.
// Input stream (s_axis_*): one request item per handshake, action plus the
// frame to free. Output stream (m_axis_*): exactly one result item per
// request, in order: status, allocated frame and free count after the request.
// Each item runs in an accept cycle and an execute cycle: the accept cycle issues reads of the free-stack
// memory (top entry) and of the free-flag memory (the frame named), and the
// next cycle checks, writes both memories back and loads the output register.
// No new item is taken until the last one has written both memories back and
// loaded its result into the output register.
// The block holds one item at a time, so reads never overlap a pending write.
// When the receiver stalls, the result waits in the output register and no
// further item is accepted until it is taken.
// Reset clears the controls, sets the free count to every allocatable frame
// and takes no clearing pass: a low-water mark of the stack count tells which
// stack slots and flags were ever written; anything below it reads as its
// reset value (stack slot i holds frame TOTAL_FRAMES-1-i, every flag is set).
// Requests can be accepted as soon as reset is released.
module page_frame_allocator #(
  parameter int TOTAL_FRAMES     = 4096,
  parameter int FIRST_FREE_FRAME = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // [1:0] action, [21:2] frame_index, [23:22] zero
  input  logic [pfa_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // [1:0] status, [13:2] alloc_frame, [25:14] free_count, [31:26] zero
  output logic [pfa_pkg::OUT_W-1:0] m_axis_tdata
);
  import pfa_pkg::*;

  localparam int ALLOC_FRAMES = (TOTAL_FRAMES > FIRST_FREE_FRAME) ?
                                (TOTAL_FRAMES - FIRST_FREE_FRAME) : 0;
  localparam int STACK_SLOTS  = (ALLOC_FRAMES > 0) ? ALLOC_FRAMES : 1;
  localparam int SAW          = (STACK_SLOTS > 1) ? $clog2(STACK_SLOTS) : 1;
  localparam int CW           = $clog2(STACK_SLOTS + 1);
  localparam int FW           = $clog2(TOTAL_FRAMES);
  localparam int CMP_W        = IDX_W + 1;

  localparam logic [CMP_W-1:0] TOTAL_L = CMP_W'(TOTAL_FRAMES);
  localparam logic [CMP_W-1:0] FIRST_L = CMP_W'(FIRST_FREE_FRAME);
  localparam logic [CW-1:0]    ALLOC_L = CW'(ALLOC_FRAMES);
  localparam logic [FW-1:0]    LAST_F  = FW'(TOTAL_FRAMES - 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  // State memories
  logic [FW-1:0] stack_mem [STACK_SLOTS];
  logic          flag_mem  [TOTAL_FRAMES];

  logic          state;
  logic [CW-1:0] count;
  logic [CW-1:0] low_mark;
  req_t          req_q;
  logic          in_range_q;
  logic [FW-1:0] stack_q;
  logic          flag_q;

  req_t          req_in;
  logic          in_accept;
  logic          in_range;
  logic [SAW-1:0] stack_raddr;
  logic [FW-1:0] flag_raddr;

  // Execute-cycle signals
  logic [CW-1:0] top_slot;
  logic [FW-1:0] pop_frame;
  logic [FW-1:0] idx_slot;
  logic          flag_cur;
  logic [1:0]    status;
  logic [FW-1:0] frame;
  logic [CW-1:0] count_next;
  logic [CW-1:0] low_mark_next;
  logic          stack_we;
  logic          flag_we;
  logic [FW-1:0] flag_waddr;
  logic          flag_wdata;
  res_t          res;

  assign req_in        = req_t'(s_axis_tdata[IDX_W+1:0]);
  assign s_axis_tready = (state == S_IDLE) && (!m_axis_tvalid || m_axis_tready);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Issue reads: top of stack, and flag of the frame named
  always_comb begin
    in_range    = (CMP_W'(req_in.frame_index) >= FIRST_L) &&
                  (CMP_W'(req_in.frame_index) < TOTAL_L);
    stack_raddr = (count == '0) ? '0 : SAW'(count - CW'(1));
    flag_raddr  = in_range ? FW'(req_in.frame_index) : '0;
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_q      <= req_in;
      in_range_q <= in_range;
      stack_q    <= stack_mem[stack_raddr];
      flag_q     <= flag_mem[flag_raddr];
    end
  end

  // Check and modify
  always_comb begin
    top_slot  = count - CW'(1);
    // slots below the low-water mark were never written since reset
    pop_frame = (top_slot < low_mark) ? (LAST_F - FW'(top_slot)) : stack_q;
    idx_slot  = LAST_F - FW'(req_q.frame_index);
    // a frame was only ever written once it left its reset slot
    flag_cur  = (idx_slot >= FW'(low_mark)) ? flag_q : 1'b1;

    status        = STAT_OK;
    frame         = '0;
    count_next    = count;
    low_mark_next = low_mark;
    stack_we      = 1'b0;
    flag_we       = 1'b0;
    flag_waddr    = '0;
    flag_wdata    = 1'b0;

    case (req_q.action)
      ACT_ALLOC: begin
        if (count == '0) begin
          status = STAT_EMPTY;
        end else begin
          frame      = pop_frame;
          count_next = top_slot;
          if (top_slot < low_mark) begin
            low_mark_next = top_slot;
          end
          flag_we    = 1'b1;
          flag_waddr = pop_frame;
          flag_wdata = 1'b0;
        end
      end
      ACT_FREE: begin
        if (!in_range_q) begin
          status = STAT_RANGE;
        end else if (flag_cur) begin
          status = STAT_DOUBLE;
        end else if (count < ALLOC_L) begin
          stack_we   = 1'b1;
          flag_we    = 1'b1;
          flag_waddr = FW'(req_q.frame_index);
          flag_wdata = 1'b1;
          count_next = count + CW'(1);
        end
      end
      default: begin
        // query, and the unused code
      end
    endcase

    res.status      = status;
    res.alloc_frame = OFRM_W'(32'(frame));
    res.free_count  = OCNT_W'(32'(count_next));
  end

  // Write back
  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      if (stack_we) begin
        stack_mem[SAW'(count)] <= FW'(req_q.frame_index);
      end
      if (flag_we) begin
        flag_mem[flag_waddr] <= flag_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      m_axis_tdata <= OUT_W'(res);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= ALLOC_L;
      low_mark      <= ALLOC_L;
      m_axis_tvalid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            state <= S_EXEC;
          end
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
          end
        end
        S_EXEC: begin
          count         <= count_next;
          low_mark      <= low_mark_next;
          m_axis_tvalid <= 1'b1;
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Stack never holds more than the allocatable frames
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ALLOC_L)
    else $error("free count beyond allocatable frames");

  // Low-water mark never rises above the count
  a_low_mark: assert property (@(posedge clk) disable iff (rst)
    low_mark <= count)
    else $error("low-water mark above stack count");

  // An accepted item finds the output register empty
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == S_EXEC) && !m_axis_tvalid)
    else $error("output register busy during execute");

  // Every executed item yields a result
  a_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |=> m_axis_tvalid && (state == S_IDLE))
    else $error("execute cycle gave no result");

  // Count changes only in the execute state
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |=> $stable(count))
    else $error("count changed outside execute");

endmodule
